>>> rtl/core/slt_pkg.sv
package slt_pkg;

    // operation codes carried on the slave-side tuser
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_SEARCH = 2'd3;

    // status codes carried on the master-side tuser
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam int WORD_W = 32;
    localparam int POS_W  = 5;

    // per-cell command for the current cycle
    typedef struct packed {
        logic cmp;  // latch compare flags against the held value
        logic ins;  // insert step: keep, take the new value, or take the left entry
        logic rm;   // remove step: take the right entry
    } t_cell_ctl;

endpackage

>>> rtl/core/slt_cell.sv
module slt_cell (
    input  logic                                i_clk,
    input  slt_pkg::t_cell_ctl                  i_ctl,
    input  logic                                i_occ,
    input  logic signed [slt_pkg::WORD_W-1:0]   i_value,
    input  logic signed [slt_pkg::WORD_W-1:0]   i_left_entry,
    input  logic                                i_left_lt,
    input  logic signed [slt_pkg::WORD_W-1:0]   i_right_entry,
    output logic signed [slt_pkg::WORD_W-1:0]   o_entry,
    output logic                                o_lt,
    output logic                                o_eq
);

    logic signed [slt_pkg::WORD_W-1:0] r_entry;
    logic                              r_lt;
    logic                              r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= i_occ && (r_entry < i_value);
            r_eq <= i_occ && (r_entry == i_value);
        end
        // entries below the insert slot hold, the slot takes the value, the rest move up
        if (i_ctl.ins && !r_lt) begin
            r_entry <= i_left_lt ? i_value : i_left_entry;
        end else if (i_ctl.rm) begin
            r_entry <= i_right_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

>>> rtl/core/slt_reduce.sv
module slt_reduce #(
    parameter int DEPTH = 16
) (
    input  logic [DEPTH-1:0]                    i_lt,
    input  logic [DEPTH-1:0]                    i_eq,
    input  logic signed [slt_pkg::WORD_W-1:0]   i_entries [DEPTH],
    input  logic [$clog2(DEPTH)-1:0]            i_idx,
    output logic [$clog2(DEPTH+1)-1:0]          o_slot,
    output logic [$clog2(DEPTH+1)-1:0]          o_first,
    output logic [$clog2(DEPTH+1)-1:0]          o_cnt,
    output logic signed [slt_pkg::WORD_W-1:0]   o_rd_data
);

    localparam int CW = $clog2(DEPTH+1);
    localparam int IW = $clog2(DEPTH);

    always_comb begin
        o_slot    = '0;
        o_cnt     = '0;
        o_first   = '0;
        o_rd_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            o_slot = o_slot + CW'(i_lt[i]);
            o_cnt  = o_cnt + CW'(i_eq[i]);
            if (i_idx == IW'(i)) begin
                o_rd_data = o_rd_data | i_entries[i];
            end
        end
        // lowest matching cell wins
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (i_eq[i]) begin
                o_first = CW'(i + 1);
            end
        end
    end

endmodule

>>> rtl/core/sorted_list_table_top.sv
// sorted list table: holds up to DEPTH signed 32-bit values in ascending order, duplicates
// allowed, in a row of cells, one entry per cell. each beat on the slave side carries one
// operation (insert, remove at a 1-based position, read at a position, search for a value)
// and yields exactly one beat on the master side with status, value, position, match count
// and the list length after the operation. an item is first captured; then every cell
// compares its entry with the value and latches the flags; then the flags are reduced
// (insert slot, first match, match count, read select) and, for an insert or a remove,
// the row shifts one place left or right. the result sits in an output register, so the
// next item is taken while the previous result waits; the execute cycle waits only while
// that register is still full. insert into a full table, and remove or read at position
// zero or past the end, leave the table unchanged and report the matching status
module sorted_list_table_top #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // value [31:0], position [36:32], zero pad
    input  logic [1:0]  i_s_tuser,   // mode [1:0]
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // data_out [31:0], where [36:32], match_count [41:37],
                                     // list_length [46:42], zero pad
    output logic [2:0]  o_m_tuser    // status [2:0]
);

    localparam int CW = $clog2(DEPTH+1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = (CW > slt_pkg::POS_W) ? CW : slt_pkg::POS_W;
    localparam int WW = slt_pkg::WORD_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state, n_state;

    // captured operation
    logic [1:0]                 r_mode;
    logic signed [WW-1:0]       r_value;
    logic [slt_pkg::POS_W-1:0]  r_pos;

    // number of valid entries
    logic [CW-1:0] r_count, n_count;

    // output register
    logic                       r_out_valid;
    logic [2:0]                 r_out_status;
    logic signed [WW-1:0]       r_out_data;
    logic [slt_pkg::POS_W-1:0]  r_out_where;
    logic [slt_pkg::POS_W-1:0]  r_out_cnt;
    logic [slt_pkg::POS_W-1:0]  r_out_len;

    logic accept_in;
    logic exec_go;

    // cell row
    logic signed [WW-1:0] w_entry [DEPTH];
    logic [DEPTH-1:0]     w_lt;
    logic [DEPTH-1:0]     w_eq;
    logic [DEPTH-1:0]     w_occ;

    // reductions
    logic [CW-1:0]        w_slot;
    logic [CW-1:0]        w_first;
    logic [CW-1:0]        w_mcnt;
    logic signed [WW-1:0] w_rd_data;

    // position checks
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] pos_m1;
    logic [IW-1:0] w_idx;
    logic          is_empty;
    logic          is_full;
    logic          bad_pos;

    // execute decisions
    logic                      do_ins;
    logic                      do_rm;
    logic [2:0]                n_status;
    logic signed [WW-1:0]      n_data;
    logic [CW-1:0]             n_where;
    logic [CW-1:0]             n_mcnt;

    assign accept_in  = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    // execute only once the previous result has gone or is leaving
    assign exec_go    = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);

    assign pos_ext  = PW'(r_pos);
    assign cnt_ext  = PW'(r_count);
    assign pos_m1   = pos_ext - PW'(1);
    assign w_idx    = pos_m1[IW-1:0];
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CW'(DEPTH));
    assign bad_pos  = (r_pos == '0) || (pos_ext > cnt_ext);

    // state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result and table update for the captured operation
    always_comb begin
        do_ins   = 1'b0;
        do_rm    = 1'b0;
        n_status = slt_pkg::ST_OK;
        n_data   = r_value;
        n_where  = '0;
        n_mcnt   = '0;
        n_count  = r_count;
        case (r_mode)
            slt_pkg::MODE_INSERT: begin
                if (is_full) begin
                    n_status = slt_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_where = w_slot + CW'(1);
                    n_count = r_count + CW'(1);
                end
            end
            slt_pkg::MODE_REMOVE, slt_pkg::MODE_READ: begin
                n_data = '0;
                if (is_empty) begin
                    n_status = slt_pkg::ST_EMPTY;
                end else if (bad_pos) begin
                    n_status = slt_pkg::ST_BADPOS;
                end else begin
                    n_data  = w_rd_data;
                    n_where = CW'(r_pos);
                    if (r_mode == slt_pkg::MODE_REMOVE) begin
                        do_rm   = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            slt_pkg::MODE_SEARCH: begin
                if (is_empty) begin
                    n_status = slt_pkg::ST_EMPTY;
                end else if (w_mcnt == '0) begin
                    n_status = slt_pkg::ST_NOTFOUND;
                end else begin
                    n_where = w_first;
                    n_mcnt  = w_mcnt;
                end
            end
            default: begin
                n_status = slt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_mode  <= i_s_tuser;
            r_value <= i_s_tdata[31:0];
            r_pos   <= i_s_tdata[36:32];
        end
        if (exec_go) begin
            r_out_status <= n_status;
            r_out_data   <= n_data;
            r_out_where  <= slt_pkg::POS_W'(n_where);
            r_out_cnt    <= slt_pkg::POS_W'(n_mcnt);
            r_out_len    <= slt_pkg::POS_W'(n_count);
        end
    end

    // row of cells, each linked to its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        slt_pkg::t_cell_ctl   ctl;
        logic signed [WW-1:0] left_entry;
        logic signed [WW-1:0] right_entry;
        logic                 left_lt;

        assign w_occ[g]  = (CW'(g) < r_count);
        assign ctl.cmp   = (r_state == S_CMP);
        assign ctl.ins   = exec_go && do_ins;
        // cells from the removed position upward take their right neighbor
        assign ctl.rm    = exec_go && do_rm && (IW'(g) >= w_idx);

        if (g == 0) begin : g_first
            assign left_entry = r_value;
            assign left_lt    = 1'b1;
        end else begin : g_mid
            assign left_entry = w_entry[g-1];
            assign left_lt    = w_lt[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_entry = w_entry[g];
        end else begin : g_inner
            assign right_entry = w_entry[g+1];
        end

        slt_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_occ         (w_occ[g]),
            .i_value       (r_value),
            .i_left_entry  (left_entry),
            .i_left_lt     (left_lt),
            .i_right_entry (right_entry),
            .o_entry       (w_entry[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g])
        );
    end

    slt_reduce #(
        .DEPTH (DEPTH)
    ) u_reduce (
        .i_lt      (w_lt),
        .i_eq      (w_eq),
        .i_entries (w_entry),
        .i_idx     (w_idx),
        .o_slot    (w_slot),
        .o_first   (w_first),
        .o_cnt     (w_mcnt),
        .o_rd_data (w_rd_data)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {1'b0, r_out_len, r_out_cnt, r_out_where, r_out_data};

    // the list never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // a new result only appears after an execute cycle
    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_EXEC))
        else $error("result without execute");

    // a refused insert leaves the length alone
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && (r_mode == slt_pkg::MODE_INSERT) && is_full) |=> $stable(r_count))
        else $error("insert into full table changed length");

endmodule
